@@ design/tftp_lockstep_transfer_engine_assert.svh @@
// Assertion macros shared by the checker of the lockstep transfer engine.
// Both macros sample on the rising edge of clk; the first one is switched
// off while rst is high, the second one also watches the reset cycles.
`ifndef TFTP_LOCKSTEP_TRANSFER_ENGINE_ASSERT_SVH
`define TFTP_LOCKSTEP_TRANSFER_ENGINE_ASSERT_SVH

`define TLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define TLE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/tle_pkg.sv @@
// ----------------------------------------------------------------------------
// tle_pkg
// Types, codes and sizes shared by the lockstep transfer engine modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tle_pkg;

  localparam int LEN_W          = 10;
  localparam int BLOCK_BYTES    = 512;
  localparam int TLE_FIFO_DEPTH = 2;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 8;

  localparam logic [LEN_W-1:0] BLOCK_LEN = LEN_W'(BLOCK_BYTES);

  // Actions of an input word.
  localparam logic [1:0] ACT_START  = 2'd0;
  localparam logic [1:0] ACT_PACKET = 2'd1;

  // Opcodes, also used for the last opcode sent (none while idle).
  localparam logic [2:0] OPC_NONE = 3'd0;
  localparam logic [2:0] OPC_RRQ  = 3'd1;
  localparam logic [2:0] OPC_WRQ  = 3'd2;
  localparam logic [2:0] OPC_DATA = 3'd3;
  localparam logic [2:0] OPC_ACK  = 3'd4;
  localparam logic [2:0] OPC_ERR  = 3'd5;

  // Result status codes.
  localparam logic [2:0] ST_RUN   = 3'd0;
  localparam logic [2:0] ST_DONE  = 3'd1;
  localparam logic [2:0] ST_RETRY = 3'd2;
  localparam logic [2:0] ST_PROTO = 3'd3;
  localparam logic [2:0] ST_PEER  = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_ROLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_RUNNING = 2'd2;

  typedef struct packed {
    logic [1:0]       action;
    logic [15:0]      opcode;
    logic [15:0]      block_number;
    logic [LEN_W-1:0] packet_length;
    logic [LEN_W-1:0] file_bytes;
    logic [15:0]      start_block;
  } in_item_t;

  typedef struct packed {
    logic             send_valid;
    logic [2:0]       send_opcode;
    logic [15:0]      send_block;
    logic [LEN_W-1:0] send_data_length;
    logic [LEN_W-1:0] write_length;
    logic [2:0]       status;
  } out_item_t;

  // Event classes found by the front end.
  typedef enum logic [2:0] {
    EV_START_IDLE,
    EV_START_REQ,
    EV_START_BAD,
    EV_PKT_BAD,
    EV_PKT,
    EV_TIMEOUT
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t         kind;
    logic [2:0]       opc;
    logic [15:0]      blk;
    logic [15:0]      sblk;
    logic [LEN_W-1:0] dlen;
    logic [LEN_W-1:0] fsat;
    logic             data_long;
    logic             ack_len_bad;
  } q_entry_t;

endpackage

`default_nettype wire

@@ design/tle_front.sv @@
// ----------------------------------------------------------------------------
// tle_front
// Takes input words and classifies them for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tle_front import tle_pkg::*; (
  input  wire in_item_t in_data,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire logic     full,
  output logic          push,
  output q_entry_t      entry
);

  logic [LEN_W-1:0] dlen;

  assign in_stall = full;
  assign push     = in_valid && !full;
  assign dlen     = in_data.packet_length - LEN_W'(4);

  always_comb begin
    entry             = '0;
    entry.opc         = in_data.opcode[2:0];
    entry.blk         = in_data.block_number;
    entry.sblk        = in_data.start_block;
    entry.dlen        = dlen;
    entry.fsat        = (in_data.file_bytes > BLOCK_LEN) ? BLOCK_LEN : in_data.file_bytes;
    entry.data_long   = dlen > BLOCK_LEN;
    entry.ack_len_bad = in_data.packet_length != LEN_W'(4);
    unique case (in_data.action)
      ACT_START: begin
        if (in_data.opcode == 16'(OPC_NONE)) begin
          entry.kind = EV_START_IDLE;
        end else if (in_data.opcode == 16'(OPC_RRQ) || in_data.opcode == 16'(OPC_WRQ)) begin
          entry.kind = EV_START_REQ;
        end else begin
          entry.kind = EV_START_BAD;
        end
      end
      ACT_PACKET: begin
        if (in_data.packet_length < LEN_W'(4) || in_data.opcode < 16'(OPC_RRQ) ||
            in_data.opcode > 16'(OPC_ERR)) begin
          entry.kind = EV_PKT_BAD;
        end else begin
          entry.kind = EV_PKT;
        end
      end
      // Both remaining action codes are timeout ticks.
      default: entry.kind = EV_TIMEOUT;
    endcase
  end

endmodule

`default_nettype wire

@@ design/tle_queue.sv @@
// ----------------------------------------------------------------------------
// tle_queue
// Short first-in first-out queue of classified events.
// ----------------------------------------------------------------------------
`default_nettype none

module tle_queue import tle_pkg::*; #(
  parameter int DEPTH = TLE_FIFO_DEPTH  // 2 to 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire q_entry_t push_data,
  output logic          full,
  input  wire logic     pop,
  output logic          head_valid,
  output q_entry_t      head_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t        mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full       = count == CW'(DEPTH);
  assign head_valid = count != '0;
  assign head_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/tle_back.sv @@
// ----------------------------------------------------------------------------
// tle_back
// Transfer state, configuration registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tle_back import tle_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  head_valid,
  input  wire q_entry_t              head_data,
  output logic                       pop,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data
);

  typedef enum logic [2:0] {
    H_NONE,
    H_DATA,
    H_ACK,
    H_PERR,
    H_RRQ,
    H_WRQ
  } handler_t;

  logic            server_role;
  logic [7:0]      retry_limit;
  logic            keep_running;

  logic [2:0]       lso, lso_next;
  logic [15:0]      exp_blk, exp_blk_next;
  logic [LEN_W-1:0] ldl, ldl_next;
  logic [15:0]      lsb, lsb_next;
  logic [7:0]       rc, rc_next;

  out_item_t        res;
  handler_t         h;
  logic [15:0]      exp_inc;
  logic             blk_eq;
  logic             blk_prev;
  logic             retry_full;
  logic             ack_now;

  assign cfg_ready  = 1'b1;
  assign pop        = head_valid && (!out_valid || !out_stall);
  assign exp_inc    = exp_blk + 16'd1;
  assign blk_eq     = head_data.blk == exp_blk;
  assign blk_prev   = head_data.blk == exp_blk - 16'd1;
  assign retry_full = rc >= retry_limit;

  // Which receive handler applies, given the last opcode sent and the role.
  always_comb begin
    h = H_NONE;
    if (lso == OPC_DATA && head_data.opc == OPC_ACK) h = H_ACK;
    if (lso == OPC_ACK && head_data.opc == OPC_DATA) h = H_DATA;
    if (server_role) begin
      if (lso == OPC_NONE && head_data.opc == OPC_RRQ) h = H_RRQ;
      if (lso == OPC_NONE && head_data.opc == OPC_WRQ) h = H_WRQ;
    end else begin
      if (lso == OPC_RRQ && head_data.opc == OPC_DATA) h = H_DATA;
      if (lso == OPC_RRQ && head_data.opc == OPC_ERR)  h = H_PERR;
      if (lso == OPC_WRQ && head_data.opc == OPC_ACK)  h = H_ACK;
      if (lso == OPC_WRQ && head_data.opc == OPC_ERR)  h = H_PERR;
    end
  end

  always_comb begin
    res          = '0;
    res.status   = ST_RUN;
    lso_next     = lso;
    exp_blk_next = exp_blk;
    ldl_next     = ldl;
    lsb_next     = lsb;
    rc_next      = rc;
    ack_now      = 1'b0;
    unique case (head_data.kind)
      EV_START_IDLE: begin
        rc_next  = '0;
        lso_next = OPC_NONE;
      end
      EV_START_BAD: begin
        rc_next    = '0;
        res.status = ST_PROTO;
      end
      EV_START_REQ: begin
        rc_next         = '0;
        exp_blk_next    = head_data.sblk;
        ldl_next        = BLOCK_LEN;
        res.send_valid  = 1'b1;
        res.send_opcode = head_data.opc;
        lso_next        = head_data.opc;
        lsb_next        = '0;
      end
      EV_PKT_BAD: res.status = ST_PROTO;
      EV_TIMEOUT: begin
        if (lso != OPC_NONE) begin
          if (retry_full) begin
            res.status = ST_RETRY;
          end else begin
            rc_next              = rc + 8'd1;
            res.send_valid       = 1'b1;
            res.send_opcode      = lso;
            res.send_block       = lsb;
            res.send_data_length = (lso == OPC_DATA) ? ldl : '0;
          end
        end
      end
      EV_PKT: begin
        case (h)
          H_DATA: begin
            if (head_data.data_long) begin
              res.status = ST_PROTO;
            end else if (blk_eq) begin
              exp_blk_next     = exp_inc;
              rc_next          = '0;
              res.write_length = head_data.dlen;
              ack_now          = 1'b1;
            end else if (blk_prev) begin
              if (retry_full) begin
                res.status = ST_RETRY;
              end else begin
                rc_next = rc + 8'd1;
                ack_now = 1'b1;
              end
            end else begin
              res.status = ST_PROTO;
            end
            // A short block, a duplicate one included, ends the transfer unless keep_running is set.
            if (ack_now) begin
              res.send_valid  = 1'b1;
              res.send_opcode = OPC_ACK;
              res.send_block  = head_data.blk;
              lso_next        = OPC_ACK;
              lsb_next        = head_data.blk;
              res.status      = (head_data.dlen == BLOCK_LEN || keep_running) ?
                                ST_RUN : ST_DONE;
            end
          end
          H_ACK: begin
            if (head_data.ack_len_bad) begin
              res.status = ST_PROTO;
            end else if (blk_eq) begin
              // Nothing left to send after a short block: the transfer is done.
              if (head_data.fsat == '0 && ldl < BLOCK_LEN) begin
                res.status = ST_DONE;
              end else begin
                ldl_next             = head_data.fsat;
                exp_blk_next         = exp_inc;
                rc_next              = '0;
                res.send_valid       = 1'b1;
                res.send_opcode      = OPC_DATA;
                res.send_block       = exp_inc;
                res.send_data_length = head_data.fsat;
                lso_next             = OPC_DATA;
                lsb_next             = exp_inc;
              end
            end else if (blk_prev) begin
              if (retry_full) begin
                res.status = ST_RETRY;
              end else begin
                rc_next              = rc + 8'd1;
                res.send_valid       = 1'b1;
                res.send_opcode      = OPC_DATA;
                res.send_block       = exp_blk;
                res.send_data_length = ldl;
                lso_next             = OPC_DATA;
                lsb_next             = exp_blk;
              end
            end else begin
              res.status = ST_PROTO;
            end
          end
          H_PERR: res.status = ST_PEER;
          H_RRQ: begin
            // A read request acts as an acknowledge of block zero.
            rc_next              = '0;
            exp_blk_next         = 16'd1;
            ldl_next             = head_data.fsat;
            res.send_valid       = 1'b1;
            res.send_opcode      = OPC_DATA;
            res.send_block       = 16'd1;
            res.send_data_length = head_data.fsat;
            lso_next             = OPC_DATA;
            lsb_next             = 16'd1;
          end
          H_WRQ: begin
            rc_next         = '0;
            exp_blk_next    = 16'd1;
            res.send_valid  = 1'b1;
            res.send_opcode = OPC_ACK;
            lso_next        = OPC_ACK;
            lsb_next        = '0;
          end
          default: res.status = ST_PROTO;
        endcase
      end
      default: res.status = ST_RUN;
    endcase
    if (res.status != ST_RUN) begin
      lso_next = OPC_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      lso          <= OPC_NONE;
      exp_blk      <= '0;
      ldl          <= '0;
      lsb          <= '0;
      rc           <= '0;
      server_role  <= 1'b0;
      retry_limit  <= 8'd5;
      keep_running <= 1'b0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        lso       <= lso_next;
        exp_blk   <= exp_blk_next;
        ldl       <= ldl_next;
        lsb       <= lsb_next;
        rc        <= rc_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SERVER_ROLE:  server_role  <= cfg_data[0];
          CFG_RETRY_LIMIT:  retry_limit  <= cfg_data;
          CFG_KEEP_RUNNING: keep_running <= cfg_data[0];
          default:          server_role  <= server_role;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

@@ design/tftp_lockstep_transfer_engine.sv @@
// ----------------------------------------------------------------------------
// tftp_lockstep_transfer_engine
// Control side of one end of a stop-and-wait file transfer.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_data) carries one event per
//   word: a start request, a received packet header or a timeout tick. The
//   output channel (out_valid, out_stall, out_data) returns exactly one
//   word per event: the packet to send, the bytes to write and a status.
//   The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
//   is always ready; the user must write it only while no event is in
//   flight, which the block itself does not enforce.
// Timing:
//   An accepted word is classified and written into the queue; its result
//   is computed at the queue head and loaded into the output register when
//   it leaves the queue, only while that register is empty or unstalled.
//   One word per cycle is sustained each way while out_stall is low.
// Reset and stalls:
//   rst clears the queue, the output valid flag and the transfer state and
//   loads the register defaults (client role, retry limit 5). While
//   out_stall is high the result holds; the queue keeps taking words until
//   it is full, then in_stall goes high.
// ----------------------------------------------------------------------------
`default_nettype none

module tftp_lockstep_transfer_engine import tle_pkg::*; #(
  parameter int FIFO_DEPTH = TLE_FIFO_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic     full;
  logic     push;
  q_entry_t entry;
  logic     pop;
  logic     head_valid;
  q_entry_t head_data;

  tle_front u_front (
    .in_data  (in_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .full     (full),
    .push     (push),
    .entry    (entry)
  );

  tle_queue #(
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  tle_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

@@ design/tle_checker.sv @@
// ----------------------------------------------------------------------------
// tle_checker
// Port-level assertions on the lockstep transfer engine, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tftp_lockstep_transfer_engine_assert.svh"

module tle_checker import tle_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  `TLE_ASSERT_RST(a_reset_empty, rst |=> !out_valid && !in_stall, "not empty after reset")

  `TLE_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled word changed")

  `TLE_ASSERT(a_no_send_zero, out_valid && !out_data.send_valid |-> out_data.send_opcode == OPC_NONE && out_data.send_block == 16'd0 && out_data.send_data_length == '0, "fields set without a send")

  `TLE_ASSERT(a_write_acks, out_valid && out_data.write_length != '0 |-> out_data.send_valid && out_data.send_opcode == OPC_ACK, "written block not acknowledged")

  `TLE_ASSERT(a_ranges, out_valid |-> out_data.status <= ST_PEER && out_data.send_data_length <= BLOCK_LEN, "result field out of range")

endmodule

bind tftp_lockstep_transfer_engine tle_checker u_tle_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
